// ----- hdl/tds_pkg.sv -----
// Shared types and constants for the tone divider select block.
`default_nettype none

package tds_pkg;

  // Field widths
  localparam int CLOCK_W    = 26;
  localparam int HZ_W       = 24;
  localparam int DUR_W      = 32;
  localparam int TOP_W      = 16;
  localparam int CODE_W     = 4;
  localparam int TOGGLE_W   = 31;
  localparam int STATUS_W   = 2;
  localparam int PRODUCT_W  = HZ_W + DUR_W;

  // Long division: one quotient bit per cell
  localparam int DIV_STEPS  = 31;
  localparam int HALF_W     = CLOCK_W - 1;
  localparam int TREM_W     = 9;

  // Toggle divider: 2*p/1000 == p/500; saturates once p >= 1000 * 2^30
  localparam logic [TREM_W:0]      TOGGLE_DIVISOR = 10'd500;
  localparam logic [PRODUCT_W-1:0] TOGGLE_SAT_PRODUCT = 56'd1073741824000;
  localparam logic [TOGGLE_W-1:0]  TOGGLE_SAT = 31'h7FFF_FFFF;

  // Prescale search
  localparam logic [31:0] TOP_LIMIT    = 32'd65535;
  localparam int          MAX_PRESCALE = 10;

  // Configuration
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 26'd14000000;
  localparam logic REG_TIMER_CLOCK = 1'b0;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIGH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOW  = 2'd3;

  typedef struct packed {
    logic                   hz_zero;
    logic                   timed;
    logic                   sat;
    logic [HZ_W-1:0]        divisor;
    logic [HZ_W-1:0]        qrem;
    logic [DIV_STEPS-1:0]   qdvd;
    logic [DIV_STEPS-1:0]   qquo;
    logic [TREM_W-1:0]      trem;
    logic [DIV_STEPS-1:0]   tdvd;
    logic [DIV_STEPS-1:0]   tquo;
  } cell_data_t;

endpackage

`default_nettype wire

// ----- hdl/tds_front.sv -----
// Entry stage: registers the request, forms hz*duration and seeds the divider chain.
`default_nettype none

module tds_front (
  input  wire                               clk,
  input  wire                               rst,
  input  wire logic [tds_pkg::CLOCK_W-1:0]  clock_hz,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire logic [tds_pkg::HZ_W-1:0]     tone_hz,
  input  wire logic [tds_pkg::DUR_W-1:0]    duration_ms,
  output logic                              valid,
  input  wire                               ready_in,
  output tds_pkg::cell_data_t               data
);

  logic [tds_pkg::HZ_W-1:0]      hz;
  logic [tds_pkg::PRODUCT_W-1:0] product;
  logic [tds_pkg::HALF_W-1:0]    half_clock;
  logic                          timed;

  assign in_ready = !valid || ready_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hz         <= tone_hz;
      product    <= tds_pkg::PRODUCT_W'(tone_hz) * tds_pkg::PRODUCT_W'(duration_ms);
      half_clock <= clock_hz[tds_pkg::CLOCK_W-1:1];
      timed      <= (duration_ms != '0);
    end
  end

  always_comb begin
    data         = '0;
    data.hz_zero = (hz == '0);
    data.timed   = timed;
    data.sat     = (product >= tds_pkg::TOGGLE_SAT_PRODUCT);
    data.divisor = hz;
    data.qrem    = '0;
    data.qdvd    = tds_pkg::DIV_STEPS'(half_clock);
    data.qquo    = '0;
    data.trem    = product[tds_pkg::DIV_STEPS +: tds_pkg::TREM_W];
    data.tdvd    = product[tds_pkg::DIV_STEPS-1:0];
    data.tquo    = '0;
  end

endmodule

`default_nettype wire

// ----- hdl/tds_div_cell.sv -----
// One division cell: a single restoring step for both the period and toggle quotients.
`default_nettype none

module tds_div_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       valid_in,
  output logic                      ready_out,
  input  wire tds_pkg::cell_data_t  data_in,
  output logic                      valid,
  input  wire                       ready_in,
  output tds_pkg::cell_data_t       data
);

  tds_pkg::cell_data_t         data_next;
  logic [tds_pkg::HZ_W:0]      qshift;
  logic [tds_pkg::HZ_W:0]      qdiff;
  logic                        qge;
  logic [tds_pkg::TREM_W:0]    tshift;
  logic [tds_pkg::TREM_W:0]    tdiff;
  logic                        tge;

  assign ready_out = !valid || ready_in;

  always_comb begin
    qshift = {data_in.qrem, data_in.qdvd[tds_pkg::DIV_STEPS-1]};
    qdiff  = qshift - {1'b0, data_in.divisor};
    qge    = (qshift >= {1'b0, data_in.divisor});
    tshift = {data_in.trem, data_in.tdvd[tds_pkg::DIV_STEPS-1]};
    tdiff  = tshift - tds_pkg::TOGGLE_DIVISOR;
    tge    = (tshift >= tds_pkg::TOGGLE_DIVISOR);

    data_next      = data_in;
    data_next.qrem = qge ? qdiff[tds_pkg::HZ_W-1:0] : qshift[tds_pkg::HZ_W-1:0];
    data_next.qdvd = {data_in.qdvd[tds_pkg::DIV_STEPS-2:0], 1'b0};
    data_next.qquo = {data_in.qquo[tds_pkg::DIV_STEPS-2:0], qge};
    data_next.trem = tge ? tdiff[tds_pkg::TREM_W-1:0] : tshift[tds_pkg::TREM_W-1:0];
    data_next.tdvd = {data_in.tdvd[tds_pkg::DIV_STEPS-2:0], 1'b0};
    data_next.tquo = {data_in.tquo[tds_pkg::DIV_STEPS-2:0], tge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tds_finish.sv -----
// Final stage: prescale search, status decode and the output register.
`default_nettype none

module tds_finish (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                valid_in,
  output logic                               ready_out,
  input  wire tds_pkg::cell_data_t           data_in,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [tds_pkg::TOP_W-1:0]          top_value,
  output logic [tds_pkg::CODE_W-1:0]         prescale_code,
  output logic [tds_pkg::TOGGLE_W-1:0]       toggle_total,
  output logic                               timed,
  output logic [tds_pkg::STATUS_W-1:0]       status
);

  logic [tds_pkg::HALF_W-1:0]   q;
  logic [tds_pkg::HALF_W-1:0]   s;
  logic [tds_pkg::HALF_W-1:0]   s_less;
  logic                         found;
  logic [tds_pkg::CODE_W-1:0]   code_sel;
  logic [tds_pkg::TOP_W-1:0]    top_sel;
  logic [tds_pkg::TOP_W-1:0]    top_value_next;
  logic [tds_pkg::CODE_W-1:0]   prescale_code_next;
  logic [tds_pkg::TOGGLE_W-1:0] toggle_total_next;
  logic                         timed_next;
  logic [tds_pkg::STATUS_W-1:0] status_next;

  assign ready_out = !out_valid || out_ready;

  // Walk down from the largest exponent so the smallest fitting one wins.
  always_comb begin
    q        = data_in.qquo[tds_pkg::HALF_W-1:0];
    found    = 1'b0;
    code_sel = '0;
    top_sel  = '0;
    s        = '0;
    s_less   = '0;
    for (int k = tds_pkg::MAX_PRESCALE; k >= 0; k--) begin
      s      = q >> k;
      s_less = s - 1'b1;
      if ((s != '0) && (32'(s_less) <= tds_pkg::TOP_LIMIT)) begin
        found    = 1'b1;
        code_sel = tds_pkg::CODE_W'(k);
        top_sel  = s_less[tds_pkg::TOP_W-1:0];
      end
    end

    top_value_next     = '0;
    prescale_code_next = '0;
    toggle_total_next  = '0;
    timed_next         = 1'b0;
    if (data_in.hz_zero) begin
      status_next = tds_pkg::ST_ZERO;
    end else if (q == '0) begin
      status_next = tds_pkg::ST_HIGH;
    end else if (!found) begin
      status_next = tds_pkg::ST_LOW;
    end else begin
      status_next        = tds_pkg::ST_OK;
      top_value_next     = top_sel;
      prescale_code_next = code_sel;
      toggle_total_next  = data_in.sat ? tds_pkg::TOGGLE_SAT : data_in.tquo;
      timed_next         = data_in.timed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      top_value     <= top_value_next;
      prescale_code <= prescale_code_next;
      toggle_total  <= toggle_total_next;
      timed         <= timed_next;
      status        <= status_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tone_divider_select.sv -----
// Top level of the tone divider select block: config register, entry stage, cell chain, output.
//
// Usage:
//   A request (tone_hz, duration_ms) enters on in_valid/in_ready; one result
//   (top_value, prescale_code, toggle_total, timed, status) leaves on
//   out_valid/out_ready for every request, in order.
//   The timer clock register sits behind an APB-style port at byte address 0;
//   write it only while no request is in flight.
// Pipeline: one entry stage (hz*duration product), 31 division cells and one
//   output stage.
// Throughput: one item per cycle while out_ready is high. Every stage has its own valid bit, and a
//   stage takes new data whenever it is empty or its successor moves, so the
//   cell chain drains bubbles and keeps accepting while a result waits.
// Stall: when out_ready is low the result holds in the output register and the
//   chain fills up behind it; in_ready drops only once every stage is full.
// Reset: clears all valid bits and loads the timer clock register with
//   14000000. No clearing pass is needed.
`default_nettype none

module tone_divider_select (
  input  wire                                clk,
  input  wire                                rst,
  // APB-style configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Request channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire logic [tds_pkg::HZ_W-1:0]      tone_hz,
  input  wire logic [tds_pkg::DUR_W-1:0]     duration_ms,
  // Result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [tds_pkg::TOP_W-1:0]          top_value,
  output logic [tds_pkg::CODE_W-1:0]         prescale_code,
  output logic [tds_pkg::TOGGLE_W-1:0]       toggle_total,
  output logic                               timed,
  output logic [tds_pkg::STATUS_W-1:0]       status
);

  logic [tds_pkg::CLOCK_W-1:0] timer_clock_hz;

  // Links between stages: link 0 leaves the entry stage, link DIV_STEPS
  // leaves the last cell.
  logic                 link_valid [tds_pkg::DIV_STEPS+1];
  logic                 link_ready [tds_pkg::DIV_STEPS+1];
  tds_pkg::cell_data_t  link_data  [tds_pkg::DIV_STEPS+1];

  // Config register: write on the access cycle, read back on the same port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= tds_pkg::CLOCK_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == tds_pkg::REG_TIMER_CLOCK)) begin
      timer_clock_hz <= pwdata[tds_pkg::CLOCK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tds_pkg::REG_TIMER_CLOCK) begin
      prdata = 32'(timer_clock_hz);
    end
  end

  // Entry: register the request and form the product for the toggle count.
  tds_front u_front (
    .clk         (clk),
    .rst         (rst),
    .clock_hz    (timer_clock_hz),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tone_hz     (tone_hz),
    .duration_ms (duration_ms),
    .valid       (link_valid[0]),
    .ready_in    (link_ready[0]),
    .data        (link_data[0])
  );

  // Cell chain: each cell retires one quotient bit of the half-period count
  // and one of the toggle count, then hands the item to its neighbor.
  for (genvar i = 0; i < tds_pkg::DIV_STEPS; i++) begin : g_cell
    tds_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (link_valid[i]),
      .ready_out (link_ready[i]),
      .data_in   (link_data[i]),
      .valid     (link_valid[i+1]),
      .ready_in  (link_ready[i+1]),
      .data      (link_data[i+1])
    );
  end

  // Finish: pick the prescale exponent, decode status and hold the result.
  tds_finish u_finish (
    .clk           (clk),
    .rst           (rst),
    .valid_in      (link_valid[tds_pkg::DIV_STEPS]),
    .ready_out     (link_ready[tds_pkg::DIV_STEPS]),
    .data_in       (link_data[tds_pkg::DIV_STEPS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .top_value     (top_value),
    .prescale_code (prescale_code),
    .toggle_total  (toggle_total),
    .timed         (timed),
    .status        (status)
  );

endmodule

`default_nettype wire

// ----- tb/tone_plan_pkg.sv -----
// Expected-result model and in-order result checker for the tone divider select testbench.
package tone_plan_pkg;
  import tds_pkg::*;

  typedef struct packed {
    logic [TOP_W-1:0]    top_value;
    logic [CODE_W-1:0]   prescale_code;
    logic [TOGGLE_W-1:0] toggle_total;
    logic                timed;
    logic [STATUS_W-1:0] status;
  } tone_plan_t;

  localparam logic [63:0] MS_PER_S = 64'd1000;

  class tone_plan_checker;
    logic [CLOCK_W-1:0] clock_hz;
    tone_plan_t         pending_plans[$];
    int                 mismatches;

    function new();
      clock_hz = CLOCK_RESET;
      mismatches = 0;
    endfunction

    // Mirror the timer clock register; only the low 26 bits are kept.
    function void set_clock(logic [31:0] value);
      clock_hz = value[CLOCK_W-1:0];
    endfunction

    function int pending();
      return pending_plans.size();
    endfunction

    // Work out divider, prescale and toggle count for one request.
    function tone_plan_t plan_tone(logic [HZ_W-1:0] hz, logic [DUR_W-1:0] dur);
      tone_plan_t  plan;
      logic [63:0] quot;
      logic [63:0] scaled;
      logic [63:0] toggles;
      bit          found;
      plan = '0;
      found = 1'b0;
      if (hz == '0) begin
        plan.status = ST_ZERO;
        return plan;
      end
      quot = 64'(clock_hz >> 1) / 64'(hz);
      if (quot == 64'd0) begin
        plan.status = ST_HIGH;
        return plan;
      end
      for (int k = 0; k <= MAX_PRESCALE; k++) begin
        if (!found) begin
          scaled = quot >> k;
          if (scaled != 64'd0 && scaled - 64'd1 <= 64'(TOP_LIMIT)) begin
            found = 1'b1;
            plan.prescale_code = CODE_W'(k);
            plan.top_value = TOP_W'(scaled - 64'd1);
          end
        end
      end
      if (!found) begin
        plan = '0;
        plan.status = ST_LOW;
        return plan;
      end
      toggles = (64'(hz) * 64'(dur) * 64'd2) / MS_PER_S;
      if (toggles > 64'(TOGGLE_SAT))
        toggles = 64'(TOGGLE_SAT);
      plan.toggle_total = toggles[TOGGLE_W-1:0];
      plan.timed = (dur != '0);
      plan.status = ST_OK;
      return plan;
    endfunction

    function void note_request(logic [HZ_W-1:0] hz, logic [DUR_W-1:0] dur);
      pending_plans.push_back(plan_tone(hz, dur));
    endfunction

    // Compare one result with the oldest pending plan, field by field.
    function void check_result(tone_plan_t got);
      tone_plan_t want;
      if (pending_plans.size() == 0) begin
        $error("result with nothing pending: top_value %0d, status %0d",
               got.top_value, got.status);
        mismatches++;
        return;
      end
      want = pending_plans.pop_front();
      if (got.top_value !== want.top_value) begin
        $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
        mismatches++;
      end
      if (got.prescale_code !== want.prescale_code) begin
        $error("prescale_code: expected %0d, got %0d", want.prescale_code, got.prescale_code);
        mismatches++;
      end
      if (got.toggle_total !== want.toggle_total) begin
        $error("toggle_total: expected %0d, got %0d", want.toggle_total, got.toggle_total);
        mismatches++;
      end
      if (got.timed !== want.timed) begin
        $error("timed: expected %0d, got %0d", want.timed, got.timed);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_tone_divider_select.sv -----
// Top-level testbench for the tone divider select block: stimulus, handshakes and checking.
module tb_tone_divider_select;
  timeunit 1ns;
  timeprecision 1ps;

  import tds_pkg::*;
  import tone_plan_pkg::*;

  // Drain time; longer than an item's path through the pipeline with no stall.
  localparam int DRAIN_CYCLES = 40;
  // Long receiver hold-off; well beyond the depth of the cell chain.
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] TIMER_CLOCK_ADDR = {REG_TIMER_CLOCK, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [HZ_W-1:0]     tone_hz = '0;
  logic [DUR_W-1:0]    duration_ms = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TOP_W-1:0]    top_value;
  logic [CODE_W-1:0]   prescale_code;
  logic [TOGGLE_W-1:0] toggle_total;
  logic                timed;
  logic [STATUS_W-1:0] status;

  // Pacing controls shared between the sender, the receiver and the sequencer.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit squeeze_req = 1'b0;

  int unsigned cycle_count = 0;
  tone_plan_t  seen;
  tone_plan_checker sb = new();

  tone_divider_select dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .tone_hz(tone_hz),
    .duration_ms(duration_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .top_value(top_value),
    .prescale_code(prescale_code),
    .toggle_total(toggle_total),
    .timed(timed),
    .status(status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a tone frequency: zeros, low tones, tones the clock can reach,
  // tones near a prescale boundary, and raw 24-bit noise.
  function automatic logic [HZ_W-1:0] pick_hz();
    int          r;
    int          k;
    logic [31:0] half;
    logic [31:0] lim;
    logic [31:0] quot;
    logic [31:0] hz;
    r = $urandom_range(0, 99);
    half = 32'(sb.clock_hz >> 1);
    if (r < 5)
      return '0;
    if (r < 30)
      return HZ_W'($urandom_range(1, 2000));
    if (r < 55) begin
      lim = (half > 32'hFF_FFFF) ? 32'hFF_FFFF : half;
      if (lim == 32'd0)
        return HZ_W'($urandom);
      return HZ_W'($urandom_range(1, lim));
    end
    if (r < 75) begin
      // Aim the half-period count at 65536 or 65537 shifted up by k.
      k = $urandom_range(0, MAX_PRESCALE);
      quot = (32'd65536 + 32'($urandom_range(0, 1))) << k;
      hz = half / quot + 32'($urandom_range(0, 2));
      hz = (hz > 32'd1) ? hz - 32'd1 : 32'd1;
      return HZ_W'(hz);
    end
    return HZ_W'($urandom);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return '0;
    if (r < 40)
      return DUR_W'($urandom_range(1, 10000));
    if (r < 50)
      return 32'hFFFF_FFFF - DUR_W'($urandom_range(0, 3));
    return DUR_W'($urandom);
  endfunction

  // Offer one item, hold it until accepted, then idle as the pacing says.
  task automatic send_item(input logic [HZ_W-1:0] hz, input logic [DUR_W-1:0] dur);
    int gap;
    gap = tx_steady ? 0 : idle_cycles();
    @(negedge clk);
    in_valid <= 1'b1;
    tone_hz <= hz;
    duration_ms <= dur;
    do @(posedge clk); while (!in_ready);
    sb.note_request(hz, dur);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drain the block, then write the timer clock register over the APB port.
  task automatic set_timer_clock(input logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMER_CLOCK_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_clock(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random items; reshuffle pacing every 64 items. With squeeze set, ask the
  // receiver for a long hold-off and keep offering back to back so the chain
  // fills and in_ready drops.
  task automatic run_random(input int count, input bit squeeze);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        if (squeeze && i == 64) begin
          tx_steady = 1'b1;
          squeeze_req = 1'b1;
        end
      end
      send_item(pick_hz(), pick_duration());
    end
  endtask

  // Receiver: drive out_ready at the falling edge.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        // Hold off for a long stretch, counted here.
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        squeeze_req = 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        stall = idle_cycles();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // Check every accepted result at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.top_value = top_value;
      seen.prescale_code = prescale_code;
      seen.toggle_total = toggle_total;
      seen.timed = timed;
      seen.status = status;
      sb.check_result(seen);
    end
  end

  // Watchdog: give up on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items on the reset clock (14 MHz, half count 7000000).
    tx_steady = 1'b0;
    rx_steady = 1'b1;
    send_item(24'd0, 32'd0);                     // zero frequency, untimed
    send_item(24'd0, 32'hFFFF_FFFF);             // zero frequency, timed
    send_item(24'hFF_FFFF, 32'hFFFF_FFFF);       // too high at full scale
    send_item(24'h80_0000, 32'h8000_0000);       // too high, single bits set
    send_item(24'd7000001, 32'd5);               // just past the reachable tone
    send_item(24'd7000000, 32'd1000);            // count of one, top zero
    send_item(24'd1, 32'hFFFF_FFFF);             // lowest tone, deep prescale
    send_item(24'd1, 32'd0);                     // untimed
    send_item(24'd106, 32'd1);                   // first step past prescale 0
    send_item(24'd107, 32'd1);                   // last fit at prescale 0
    send_item(24'd3, 32'd1);                     // toggles round down to zero
    send_item(24'd999, 32'd1);
    send_item(24'd1000, 32'd1073741823);         // just under saturation
    send_item(24'd500, 32'd2147483647);          // lands on the saturated value
    send_item(24'd1000, 32'd1073741824);         // saturates
    send_item(24'd7000000, 32'hFFFF_FFFF);       // saturates at top tone
    rx_steady = 1'b0;
    send_item(24'h55_5555, 32'h5555_5555);
    send_item(24'h2A_AAAA, 32'hAAAA_AAAA);

    // Clock of 1: every nonzero tone is too high.
    set_timer_clock(32'd1);
    send_item(24'd1, 32'd7);
    run_random(40, 1'b0);
    // Clock of 0.
    set_timer_clock(32'd0);
    send_item(24'd1, 32'd7);
    run_random(40, 1'b0);
    // Clock of 2: tone 1 gives count 1.
    set_timer_clock(32'd2);
    send_item(24'd1, 32'hFFFF_FFFF);
    send_item(24'd2, 32'd9);
    run_random(40, 1'b0);
    // Upper bits of the write are dropped: register becomes all ones.
    set_timer_clock(32'hFFFF_FFFF);
    send_item(24'd1, 32'd100);
    run_random(250, 1'b0);
    // Top of the stated range, with the long receiver hold-off.
    set_timer_clock(32'd50000000);
    run_random(250, 1'b1);
    set_timer_clock(32'($urandom_range(1, 50000000)));
    run_random(250, 1'b0);
    set_timer_clock(32'(CLOCK_RESET));
    run_random(250, 1'b0);
    set_timer_clock($urandom);
    run_random(250, 1'b0);
    // Half count of 65536 at tone 1: top exactly at the limit.
    set_timer_clock(32'd131072);
    send_item(24'd1, 32'd1);
    send_item(24'd2, 32'd1);
    run_random(200, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
